>>> hdl/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude block.
// No dependencies; compiled first.
package sem_pkg;

    localparam int CFG_W        = 12;
    localparam int PIX_W        = 8;
    localparam int MAX_LINE_DEF = 2048;
    localparam int MIN_DIM      = 3;
    localparam int SAT_LIMIT    = 255;
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    typedef logic [CFG_W-1:0] cfg_word_t;
    typedef logic [PIX_W-1:0] pixel_t;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    typedef enum logic [0:0] {
        ACT_PIXEL = 1'b0,
        ACT_DRAIN = 1'b1
    } action_t;

endpackage

>>> hdl/sem_if.sv
// Valid/ready stream interfaces for the pixel input and the edge result output.
// Depends on sem_pkg for the payload types.
interface sem_pixel_if;
    logic            valid;
    logic            ready;
    logic            action;
    sem_pkg::pixel_t pixel_in;

    modport source (output valid, output action, output pixel_in, input ready);
    modport sink   (input valid, input action, input pixel_in, output ready);
endinterface

interface sem_result_if;
    logic            valid;
    logic            ready;
    sem_pkg::pixel_t edge_value;
    logic            frame_end;

    modport source (output valid, output edge_value, output frame_end, input ready);
    modport sink   (input valid, input edge_value, input frame_end, output ready);
endinterface

>>> hdl/sobel_edge_magnitude.sv
// Top level of the streaming 3x3 Sobel edge detector with L1 magnitude.
// Depends on sem_pkg and the stream interfaces in sem_if.sv.
//
// Usage: pixels enter in raster order on in_ch, one beat per pixel; a beat
// with action set to drain carries no pixel and flushes one outstanding
// result. Results leave on out_ch as the saturated value |gx|+|gy|, zero on
// the frame border, with frame_end set on the frame's last position. A result
// belongs to the pixel accepted frame_width+1 positions earlier.
// Frame width and height are written through the plain write port while the
// block is idle; each write restarts the frame position counters.
// Throughput is one beat per cycle while out_ch.ready stays high. A result is
// visible on out_ch once the beat that produces it has passed the line
// store read register and the window update, and the magnitude has gone into
// the output register. The line stores are single-port-write memories read
// once per pixel, which bounds the rate at one pixel per clock.
// Reset clears the window, the counters and the output valid; the line
// stores read as zero until each column has been written once, tracked by a
// fill count, so no clearing pass is needed. When the receiver stalls, the
// output register holds its beat, the two inner stages keep filling, and
// in_ch.ready drops once they are full.
module sobel_edge_magnitude #(
    parameter int MAX_LINE = sem_pkg::MAX_LINE_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    sem_pixel_if.sink            in_ch,
    sem_result_if.source         out_ch,
    input  logic                 cfg_we,
    input  sem_pkg::cfg_index_t  cfg_index,
    input  sem_pkg::cfg_word_t   cfg_data
);
    import sem_pkg::*;

    localparam int ColW  = (MAX_LINE > 2) ? $clog2(MAX_LINE) : 2;
    localparam int FillW = ColW + 1;
    localparam int LagW  = CFG_W + 1;
    localparam int SumW  = PIX_W + 2;
    localparam int MagW  = SumW + 1;

    typedef logic [ColW-1:0] col_t;

    typedef struct packed {
        logic emit;
        logic zero;
        logic fend;
        logic pixel;
    } item_ctl_t;

    cfg_word_t          width_reg;
    cfg_word_t          height_reg;
    cfg_word_t          w_eff;
    cfg_word_t          h_eff;

    col_t               in_col_reg;
    col_t               out_col_reg;
    cfg_word_t          out_row_reg;
    logic [LagW-1:0]    lag_reg;
    logic [FillW-1:0]   fill_reg;

    pixel_t             upper_mem [MAX_LINE];
    pixel_t             middle_mem [MAX_LINE];
    pixel_t             up_rd_reg;
    pixel_t             mid_rd_reg;

    logic               s1_valid_reg;
    item_ctl_t          s1_ctl_reg;
    col_t               s1_col_reg;
    pixel_t             s1_px_reg;
    logic               s1_seen_reg;

    logic               s2_valid_reg;
    item_ctl_t          s2_ctl_reg;
    logic [2:0][2:0][PIX_W-1:0] win_reg;

    logic               out_valid_reg;
    pixel_t             edge_reg;
    logic               fend_reg;

    logic               in_fire;
    logic               is_drain;
    logic               emit;
    logic               enter;
    logic               in_col_last;
    logic               out_col_last;
    logic               out_row_last;
    logic               border;
    logic               col_seen;
    item_ctl_t          ctl_in;
    logic               s3_free;
    logic               s2_adv;
    logic               s2_free;
    logic               s1_adv;
    pixel_t             up_val;
    pixel_t             mid_val;
    logic [SumW-1:0]    gx_pos;
    logic [SumW-1:0]    gx_neg;
    logic [SumW-1:0]    gy_pos;
    logic [SumW-1:0]    gy_neg;
    logic [SumW-1:0]    gx_abs;
    logic [SumW-1:0]    gy_abs;
    logic [MagW-1:0]    mag_sum;
    pixel_t             mag;

    always_comb
    begin
        if (width_reg < CFG_W'(MIN_DIM))
        begin
            w_eff = CFG_W'(MIN_DIM);
        end
        else if (int'(width_reg) > MAX_LINE)
        begin
            w_eff = CFG_W'(MAX_LINE);
        end
        else
        begin
            w_eff = width_reg;
        end
        if (height_reg < CFG_W'(MIN_DIM))
        begin
            h_eff = CFG_W'(MIN_DIM);
        end
        else
        begin
            h_eff = height_reg;
        end
    end

    assign in_fire      = in_ch.valid && in_ch.ready;
    assign is_drain     = (action_t'(in_ch.action) == ACT_DRAIN);
    assign in_col_last  = (CFG_W'(in_col_reg) == w_eff - 1'b1);
    assign out_col_last = (CFG_W'(out_col_reg) == w_eff - 1'b1);
    assign out_row_last = (out_row_reg == h_eff - 1'b1);
    assign border       = (out_row_reg == '0) || out_row_last
                          || (out_col_reg == '0) || out_col_last;
    assign emit         = is_drain ? (lag_reg != '0) : (lag_reg > LagW'(w_eff));
    assign enter        = in_fire && (emit || !is_drain);
    assign col_seen     = (FillW'(in_col_reg) < fill_reg);

    always_comb
    begin
        ctl_in.emit  = emit;
        ctl_in.zero  = is_drain || border;
        ctl_in.fend  = out_row_last && out_col_last;
        ctl_in.pixel = !is_drain;
    end

    assign s3_free     = !out_valid_reg || out_ch.ready;
    assign s2_adv      = s2_valid_reg && (!s2_ctl_reg.emit || s3_free);
    assign s2_free     = !s2_valid_reg || s2_adv;
    assign s1_adv      = s1_valid_reg && s2_free;
    assign in_ch.ready = !s1_valid_reg || s1_adv;

    // Configuration and frame position counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= CFG_W'(WIDTH_RESET);
            height_reg  <= CFG_W'(HEIGHT_RESET);
            in_col_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            lag_reg     <= '0;
            fill_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: height_reg <= cfg_data;
            endcase
            in_col_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            lag_reg     <= '0;
        end
        else if (in_fire)
        begin
            if (!is_drain)
            begin
                in_col_reg <= in_col_last ? '0 : in_col_reg + 1'b1;
                if (!col_seen)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                if (!emit)
                begin
                    lag_reg <= lag_reg + 1'b1;
                end
            end
            else if (emit)
            begin
                lag_reg <= lag_reg - 1'b1;
            end
            if (emit)
            begin
                if (out_col_last)
                begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_last ? '0 : out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_reg <= out_col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && !is_drain)
        begin
            mid_rd_reg             <= middle_mem[in_col_reg];
            middle_mem[in_col_reg] <= in_ch.pixel_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && !is_drain)
        begin
            up_rd_reg <= upper_mem[in_col_reg];
        end
        if (s1_adv && s1_ctl_reg.pixel)
        begin
            upper_mem[s1_col_reg] <= mid_val;
        end
    end

    assign up_val  = s1_seen_reg ? up_rd_reg : '0;
    assign mid_val = s1_seen_reg ? mid_rd_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            win_reg      <= '0;
        end
        else
        begin
            if (enter)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                s2_valid_reg <= 1'b1;
                if (s1_ctl_reg.pixel)
                begin
                    for (int r = 0; r < 3; r++)
                    begin
                        win_reg[r][0] <= win_reg[r][1];
                        win_reg[r][1] <= win_reg[r][2];
                    end
                    win_reg[0][2] <= up_val;
                    win_reg[1][2] <= mid_val;
                    win_reg[2][2] <= s1_px_reg;
                end
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (enter)
        begin
            s1_ctl_reg  <= ctl_in;
            s1_col_reg  <= in_col_reg;
            s1_px_reg   <= in_ch.pixel_in;
            s1_seen_reg <= col_seen;
        end
        if (s1_adv)
        begin
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    always_comb
    begin
        gx_pos = SumW'(win_reg[0][2]) + (SumW'(win_reg[1][2]) << 1) + SumW'(win_reg[2][2]);
        gx_neg = SumW'(win_reg[0][0]) + (SumW'(win_reg[1][0]) << 1) + SumW'(win_reg[2][0]);
        gy_pos = SumW'(win_reg[2][0]) + (SumW'(win_reg[2][1]) << 1) + SumW'(win_reg[2][2]);
        gy_neg = SumW'(win_reg[0][0]) + (SumW'(win_reg[0][1]) << 1) + SumW'(win_reg[0][2]);
        gx_abs = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
        gy_abs = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
        mag_sum = MagW'(gx_abs) + MagW'(gy_abs);
        mag = (mag_sum > MagW'(SAT_LIMIT)) ? PIX_W'(SAT_LIMIT) : mag_sum[PIX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_adv && s2_ctl_reg.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv && s2_ctl_reg.emit)
        begin
            edge_reg <= s2_ctl_reg.zero ? '0 : mag;
            fend_reg <= s2_ctl_reg.fend;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.edge_value = edge_reg;
    assign out_ch.frame_end  = fend_reg;

    a_lag_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lag_reg <= LagW'(w_eff) + 1'b1)
        else $error("lag counter exceeds frame width plus one");

    a_out_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        CFG_W'(out_col_reg) < w_eff)
        else $error("output column outside the frame");

    a_in_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        CFG_W'(in_col_reg) < w_eff)
        else $error("input column outside the frame");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(fill_reg) <= MAX_LINE)
        else $error("line store fill count exceeds the store depth");

    a_frame_end_border: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.frame_end |-> out_ch.edge_value == '0)
        else $error("last pixel of a frame gave a nonzero edge value");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for sobel_edge_magnitude: directed and random pixel streams,
// drain beats and frame settings, checked beat by beat against a scoreboard predictor.
// Depends on sem_pkg, the stream interfaces in sem_if.sv and the block's RTL.
module tb_top;
    import sem_pkg::*;

    localparam int CENTER_WEIGHT = 2;
    localparam int MAX_HEIGHT    = 4095;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT    = 5000;
    localparam int ITEM_TARGET   = 1700;
    localparam int MAX_GAP       = 11;
    localparam int MAX_REPORTS   = 10;

    localparam int STYLE_NOISE   = 0;
    localparam int STYLE_EXTREME = 1;
    localparam int STYLE_RAMP    = 2;
    localparam int STYLE_FLAT    = 3;

    typedef struct packed {
        pixel_t edge_value;
        logic   frame_end;
    } edge_beat_t;

    class edge_scoreboard;
        cfg_word_t    width_reg;
        cfg_word_t    height_reg;
        pixel_t       upper_row [MAX_LINE_DEF];
        pixel_t       middle_row [MAX_LINE_DEF];
        pixel_t       win [3][3];
        logic [10:0]  in_col;
        logic [11:0]  in_row;
        logic [10:0]  out_col;
        logic [11:0]  out_row;
        edge_beat_t   expected_edges [$];
        int           errors;
        int           pixel_beats;
        int           drain_beats;
        int           results_checked;
        int           interior_results;
        int           saturated_results;
        int           frame_ends;

        function new();
            width_reg = cfg_word_t'(WIDTH_RESET);
            height_reg = cfg_word_t'(HEIGHT_RESET);
            foreach (upper_row[i])
            begin
                upper_row[i] = '0;
                middle_row[i] = '0;
            end
            foreach (win[r, c])
            begin
                win[r][c] = '0;
            end
            restart();
        endfunction

        function void restart();
            in_col = '0;
            in_row = '0;
            out_col = '0;
            out_row = '0;
        endfunction

        function int unsigned eff_width();
            int unsigned w;
            w = width_reg;
            if (w < MIN_DIM) w = MIN_DIM;
            if (w > MAX_LINE_DEF) w = MAX_LINE_DEF;
            return w;
        endfunction

        function int unsigned eff_height();
            int unsigned h;
            h = height_reg;
            if (h < MIN_DIM) h = MIN_DIM;
            if (h > MAX_HEIGHT) h = MAX_HEIGHT;
            return h;
        endfunction

        function int unsigned backlog();
            int unsigned w;
            int unsigned total;
            w = eff_width();
            total = w * eff_height();
            return ((in_row * w + in_col) + total - (out_row * w + out_col)) % total;
        endfunction

        function int pending();
            return expected_edges.size();
        endfunction

        function void write_reg(cfg_index_t idx, cfg_word_t value);
            if (idx == REG_FRAME_WIDTH)
                width_reg = value;
            else
                height_reg = value;
            restart();
        endfunction

        function void step_pos(inout logic [10:0] col, inout logic [11:0] row,
                               input int unsigned w, input int unsigned h);
            if (int'(col) + 1 >= w)
            begin
                col = '0;
                if (int'(row) + 1 >= h)
                    row = '0;
                else
                    row = row + 1'b1;
            end
            else
            begin
                col = col + 1'b1;
            end
        endfunction

        function pixel_t grad_l1();
            int gx;
            int gy;
            int m;
            gx = (int'(win[0][2]) + CENTER_WEIGHT * int'(win[1][2]) + int'(win[2][2]))
               - (int'(win[0][0]) + CENTER_WEIGHT * int'(win[1][0]) + int'(win[2][0]));
            gy = (int'(win[2][0]) + CENTER_WEIGHT * int'(win[2][1]) + int'(win[2][2]))
               - (int'(win[0][0]) + CENTER_WEIGHT * int'(win[0][1]) + int'(win[0][2]));
            m = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
            return (m > SAT_LIMIT) ? pixel_t'(SAT_LIMIT) : pixel_t'(m);
        endfunction

        function void note_beat(action_t act, pixel_t px);
            int unsigned w;
            int unsigned h;
            int unsigned lag;
            int unsigned c;
            int          k;
            logic        border;
            edge_beat_t  r;
            w = eff_width();
            h = eff_height();
            lag = backlog();
            if (act == ACT_DRAIN)
            begin
                drain_beats++;
                if (lag == 0) return;
                r.edge_value = '0;
            end
            else
            begin
                pixel_beats++;
                c = in_col;
                for (k = 0; k < 3; k++)
                begin
                    win[k][0] = win[k][1];
                    win[k][1] = win[k][2];
                end
                win[0][2] = upper_row[c];
                win[1][2] = middle_row[c];
                win[2][2] = px;
                upper_row[c] = middle_row[c];
                middle_row[c] = px;
                step_pos(in_col, in_row, w, h);
                if (lag < w + 1) return;
                border = (out_row == 0) || (out_row == h - 1) ||
                         (out_col == 0) || (out_col == w - 1);
                r.edge_value = border ? pixel_t'(0) : grad_l1();
                if (!border) interior_results++;
                if (r.edge_value == SAT_LIMIT) saturated_results++;
            end
            r.frame_end = (out_row == h - 1) && (out_col == w - 1);
            if (r.frame_end) frame_ends++;
            expected_edges.push_back(r);
            step_pos(out_col, out_row, w, h);
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= MAX_REPORTS) $display("ERROR: %s", msg);
        endfunction

        function void check_edge(pixel_t ev, logic fe);
            edge_beat_t want;
            results_checked++;
            if (expected_edges.size() == 0)
            begin
                flag($sformatf("unexpected edge beat: value %0d frame_end %b", ev, fe));
                return;
            end
            want = expected_edges.pop_front();
            if (ev !== want.edge_value || fe !== want.frame_end)
                flag($sformatf("edge beat %0d: expected value %0d frame_end %b, got %0d %b",
                               results_checked, want.edge_value, want.frame_end, ev, fe));
        endfunction

        function void close_out();
            if (expected_edges.size() != 0)
                flag($sformatf("%0d edge beats never arrived", expected_edges.size()));
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    cfg_index_t cfg_index;
    cfg_word_t  cfg_data;

    sem_pixel_if  pix_ch ();
    sem_result_if res_ch ();

    edge_scoreboard sb;
    int     items_sent = 0;
    int     settings_used = 0;
    int     idle_cycles = 0;
    bit     in_calm = 1'b0;
    bit     out_calm = 1'b0;
    pixel_t ramp_level = '0;

    sobel_edge_magnitude u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (pix_ch),
        .out_ch    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Watchdog: no beat moved for %0d cycles.", IDLE_LIMIT);
            $display("** sobel_edge_magnitude: FAILED **");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic pixel_t draw_pixel(int style);
        case (style)
            STYLE_EXTREME: return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            STYLE_RAMP:
            begin
                ramp_level = ramp_level + pixel_t'($urandom_range(0, 24));
                return ramp_level;
            end
            STYLE_FLAT: return ($urandom_range(0, 7) == 0) ? pixel_t'($urandom) : ramp_level;
            default: return pixel_t'($urandom);
        endcase
    endfunction

    task automatic send_beat(action_t act, pixel_t px);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.action <= act;
        pix_ch.pixel_in <= px;
        do @(posedge clk); while (pix_ch.ready !== 1'b1);
        sb.note_beat(act, px);
        items_sent++;
    endtask

    task automatic write_reg(cfg_index_t idx, cfg_word_t value);
        pix_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    task automatic set_frame(cfg_word_t w, cfg_word_t h);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        settings_used++;
        in_calm = ($urandom_range(0, 3) == 0);
        out_calm = ($urandom_range(0, 3) == 0);
    endtask

    task automatic feed(int count, int style, int noise_rate);
        int i;
        for (i = 0; i < count; i++)
        begin
            if (noise_rate > 0 && $urandom_range(1, noise_rate) == 1)
                send_beat(ACT_DRAIN, pixel_t'($urandom));
            send_beat(ACT_PIXEL, draw_pixel(style));
        end
    endtask

    task automatic drain_out(int extra);
        int n;
        int i;
        n = sb.backlog() + extra;
        for (i = 0; i < n; i++)
            send_beat(ACT_DRAIN, pixel_t'($urandom));
    endtask

    initial
    begin
        int stall;
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = out_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (res_ch.valid !== 1'b1);
            sb.check_edge(res_ch.edge_value, res_ch.frame_end);
        end
    end

    initial
    begin
        pixel_t      step_frame [9];
        int          pick;
        int          w;
        int          h;
        int unsigned area;
        int          count;
        sb = new();
        rst_n = 1'b0;
        pix_ch.valid <= 1'b0;
        pix_ch.action <= ACT_PIXEL;
        pix_ch.pixel_in <= '0;
        cfg_we <= 1'b0;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data <= '0;
        step_frame = '{8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset geometry: the backlog never reaches the lag, so only drains give results.
        feed(6, STYLE_EXTREME, 0);
        drain_out(1);

        // Smallest frame with a hard vertical step; the one interior result saturates.
        set_frame(cfg_word_t'(3), cfg_word_t'(3));
        foreach (step_frame[i])
            send_beat(ACT_PIXEL, step_frame[i]);
        drain_out(1);

        set_frame(cfg_word_t'(4095), cfg_word_t'(0));
        feed(48, STYLE_NOISE, 0);
        drain_out(1);
        set_frame(cfg_word_t'(2), cfg_word_t'(4095));
        feed(14, STYLE_NOISE, 6);
        drain_out(0);

        while (items_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                w = $urandom_range(3, 10);
                h = $urandom_range(3, 6);
            end
            else if (pick == 7)
            begin
                w = $urandom_range(0, 2);
                h = $urandom_range(0, 4);
            end
            else if (pick == 8)
            begin
                w = $urandom_range(11, 40);
                h = $urandom_range(3, 4);
            end
            else
            begin
                w = $urandom_range(2048, 4095);
                h = $urandom_range(3, 4095);
            end
            set_frame(cfg_word_t'(w), cfg_word_t'(h));
            area = sb.eff_width() * sb.eff_height();
            if (area <= 200)
                count = area * $urandom_range(1, 3);
            else
                count = $urandom_range(20, 80);
            if ($urandom_range(0, 5) == 0)
                count = $urandom_range(1, count);
            feed(count, $urandom_range(STYLE_NOISE, STYLE_FLAT),
                 ($urandom_range(0, 2) == 0) ? 25 : 0);
            if ($urandom_range(0, 5) != 0)
                drain_out($urandom_range(0, 2));
        end

        pix_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        sb.close_out();
        $display("Sent %0d pixel beats and %0d drain beats over %0d frame settings.",
                 sb.pixel_beats, sb.drain_beats, settings_used);
        $display("Checked %0d edge beats: %0d interior, %0d saturated, %0d frame ends, %0d errors.",
                 sb.results_checked, sb.interior_results, sb.saturated_results,
                 sb.frame_ends, sb.errors);
        if (sb.errors == 0)
            $display("** sobel_edge_magnitude: PASSED **");
        else
            $display("** sobel_edge_magnitude: FAILED **");
        $finish;
    end

endmodule
